>>> hw/rtl/mta_pkg.sv
// Shared types, codes and microprogram for the 4x4 transform accumulator.
package mta_pkg;

  localparam int NUM_ELEM = 16;
  localparam int ACC_W    = 66;

  localparam logic [1:0] REQ_IDENT = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_TRANS = 2'd2;
  localparam logic [1:0] REQ_SCALE = 2'd3;

  localparam logic [3:0] LAST_IDX = 4'd15;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MAC     = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_LD = 3'd4;

  localparam logic [2:0] J_DISPATCH  = 3'd0;
  localparam logic [2:0] J_MAC_LOOP  = 3'd1;
  localparam logic [2:0] J_DRAIN     = 3'd2;
  localparam logic [2:0] J_WAIT_OUT  = 3'd3;
  localparam logic [2:0] J_EMIT_NEXT = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  elem_index;
    logic [31:0] elem_value;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic [31:0] z_value;
  } in_item_t;

  typedef struct packed {
    logic       in_ready;
    logic       mac_issue;
    logic       emit_rd;
    logic       emit_ld;
    logic       flip;
    logic [2:0] jump;
  } micro_word_t;

  typedef struct packed {
    logic       in_ready;
    logic       accept;
    logic       set_ident;
    logic       mac_issue;
    logic [5:0] mac_cnt;
    logic       emit_rd;
    logic [3:0] emit_idx;
    logic       emit_ld;
    logic       flip;
  } ctrl_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } status_t;

  function automatic micro_word_t micro_rom(input logic [2:0] step);
    micro_word_t w;
    w = '0;
    unique case (step)
      S_IDLE: begin
        w.in_ready = 1'b1;
        w.jump     = J_DISPATCH;
      end
      S_MAC: begin
        w.mac_issue = 1'b1;
        w.jump      = J_MAC_LOOP;
      end
      S_DRAIN: begin
        w.flip = 1'b1;
        w.jump = J_DRAIN;
      end
      S_EMIT_RD: begin
        w.emit_rd = 1'b1;
        w.jump    = J_WAIT_OUT;
      end
      S_EMIT_LD: begin
        w.emit_ld = 1'b1;
        w.jump    = J_EMIT_NEXT;
      end
      default: begin
        w.jump = J_EMIT_NEXT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/mta_sequencer.sv
// Microcoded step sequencer: step counter, product and emit counters, jumps.
module mta_sequencer
  import mta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] req_type,
  input  logic [3:0] elem_index,
  input  status_t    status,
  output ctrl_t      ctrl
);

  logic [2:0]  upc;
  logic [2:0]  upc_next;
  logic [5:0]  mac_cnt;
  logic [5:0]  mac_cnt_next;
  logic [3:0]  emit_idx;
  logic [3:0]  emit_idx_next;
  micro_word_t word;
  logic        accept;

  assign word   = micro_rom(upc);
  assign accept = word.in_ready & s_tvalid;

  always_comb begin
    upc_next      = upc;
    mac_cnt_next  = mac_cnt;
    emit_idx_next = emit_idx;
    unique case (word.jump)
      J_DISPATCH: begin
        if (accept) begin
          if (req_type == REQ_IDENT) begin
            upc_next      = S_EMIT_RD;
            emit_idx_next = '0;
          end else if (req_type == REQ_LOAD && elem_index != LAST_IDX) begin
            upc_next = S_IDLE;
          end else begin
            upc_next     = S_MAC;
            mac_cnt_next = '0;
          end
        end
      end
      J_MAC_LOOP: begin
        mac_cnt_next = mac_cnt + 6'd1;
        if (mac_cnt == 6'd63) begin
          upc_next = S_DRAIN;
        end
      end
      J_DRAIN: begin
        if (status.pipe_empty) begin
          upc_next      = S_EMIT_RD;
          emit_idx_next = '0;
        end
      end
      J_WAIT_OUT: begin
        if (status.out_free) begin
          upc_next = S_EMIT_LD;
        end
      end
      J_EMIT_NEXT: begin
        emit_idx_next = emit_idx + 4'd1;
        upc_next      = (emit_idx == LAST_IDX) ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        upc_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc      <= S_IDLE;
      mac_cnt  <= '0;
      emit_idx <= '0;
    end else begin
      upc      <= upc_next;
      mac_cnt  <= mac_cnt_next;
      emit_idx <= emit_idx_next;
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.in_ready  = word.in_ready;
    ctrl.accept    = accept;
    ctrl.set_ident = accept & (req_type == REQ_IDENT);
    ctrl.mac_issue = word.mac_issue;
    ctrl.mac_cnt   = mac_cnt;
    ctrl.emit_rd   = word.emit_rd & status.out_free;
    ctrl.emit_idx  = emit_idx;
    ctrl.emit_ld   = word.emit_ld;
    ctrl.flip      = word.flip & status.pipe_empty;
  end

endmodule

>>> hw/rtl/mta_datapath.sv
// Matrix banks, operand stage, multiply-accumulate pipeline and output register.
module mta_datapath
  import mta_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    item,
  input  ctrl_t       ctrl,
  output status_t     status,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [3:0]  out_index,
  output logic [31:0] out_value,
  output logic        last_flag
);

  localparam logic signed [31:0] ONE   = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

  logic [31:0] cmem [2*NUM_ELEM];
  logic [31:0] smem [NUM_ELEM];
  logic [NUM_ELEM-1:0] svalid;

  logic        cur;
  logic        id_flag;
  logic [1:0]  req_q;
  logic signed [31:0] x_q, y_q, z_q;

  logic [1:0]  m_c, m_r, m_i;
  logic [3:0]  op_addr, c_addr, rd_addr;
  logic signed [31:0] op_gen;

  logic [31:0] cm_q, st_q;
  logic        st_vq, diag_q;
  logic signed [31:0] opg_q;
  logic        p1_v, p1_first, p1_last;
  logic [3:0]  p1_k;

  logic signed [31:0] a_op, b_op;
  logic signed [63:0] prod_q;
  logic        p2_v, p2_first, p2_last;
  logic [3:0]  p2_k;

  logic signed [ACC_W-1:0] acc;
  logic        p3_v, p3_last;
  logic [3:0]  p3_k;
  logic signed [ACC_W-1:0] shifted;
  logic signed [31:0] sat_val;

  logic [3:0]  em_idx;

  assign m_c     = ctrl.mac_cnt[5:4];
  assign m_r     = ctrl.mac_cnt[3:2];
  assign m_i     = ctrl.mac_cnt[1:0];
  assign op_addr = {m_i, m_r};
  assign c_addr  = {m_c, m_i};
  assign rd_addr = ctrl.emit_rd ? ctrl.emit_idx : c_addr;

  always_comb begin
    op_gen = (m_r == m_i) ? ONE : '0;
    if (req_q == REQ_TRANS && m_i == 2'd3) begin
      case (m_r)
        2'd0:    op_gen = x_q;
        2'd1:    op_gen = y_q;
        2'd2:    op_gen = z_q;
        default: op_gen = ONE;
      endcase
    end else if (req_q == REQ_SCALE && m_r == m_i) begin
      case (m_r)
        2'd0:    op_gen = x_q;
        2'd1:    op_gen = y_q;
        2'd2:    op_gen = z_q;
        default: op_gen = ONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= '0;
    end else if (ctrl.accept && item.req_type == REQ_LOAD) begin
      svalid[item.elem_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && item.req_type == REQ_LOAD) begin
      smem[item.elem_index] <= item.elem_value;
    end
    if (ctrl.accept) begin
      req_q <= item.req_type;
      x_q   <= item.x_value;
      y_q   <= item.y_value;
      z_q   <= item.z_value;
    end
  end

  always_ff @(posedge clk) begin
    cm_q   <= cmem[{cur, rd_addr}];
    st_q   <= smem[op_addr];
    st_vq  <= svalid[op_addr];
    opg_q  <= op_gen;
    diag_q <= ctrl.emit_rd ? (ctrl.emit_idx[3:2] == ctrl.emit_idx[1:0]) : (m_c == m_i);
    p1_first <= (m_i == 2'd0);
    p1_last  <= (m_i == 2'd3);
    p1_k     <= {m_c, m_r};
    if (ctrl.emit_rd) begin
      em_idx <= ctrl.emit_idx;
    end
  end

  assign a_op = (req_q == REQ_LOAD) ? (st_vq ? st_q : '0) : opg_q;
  assign b_op = id_flag ? (diag_q ? ONE : '0) : cm_q;

  always_ff @(posedge clk) begin
    prod_q   <= 64'(a_op) * 64'(b_op);
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_k     <= p1_k;
    if (p2_v) begin
      acc <= p2_first ? ACC_W'(prod_q) : acc + ACC_W'(prod_q);
    end
    p3_last <= p2_last;
    p3_k    <= p2_k;
  end

  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    if (shifted > ACC_W'(V_MAX)) begin
      sat_val = V_MAX;
    end else if (shifted < ACC_W'(V_MIN)) begin
      sat_val = V_MIN;
    end else begin
      sat_val = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p3_v && p3_last) begin
      cmem[{~cur, p3_k}] <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
      p3_v    <= 1'b0;
      cur     <= 1'b0;
      id_flag <= 1'b1;
    end else begin
      p1_v <= ctrl.mac_issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
      if (ctrl.flip) begin
        cur     <= ~cur;
        id_flag <= 1'b0;
      end else if (ctrl.set_ident) begin
        id_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_ld) begin
      out_index <= em_idx;
      out_value <= id_flag ? (diag_q ? ONE : '0) : cm_q;
      last_flag <= (em_idx == LAST_IDX);
    end
  end

  assign status.pipe_empty = ~(p1_v | p2_v | p3_v);
  assign status.out_free   = ~m_tvalid | m_tready;

endmodule

>>> hw/rtl/matrix4_transform_accumulator_top.sv
// Top level of the 4x4 transform accumulator: stream ports and sequencer wiring.
//
// Holds a column-major 4x4 matrix in signed fixed point, identity after reset.
// Requests arrive on the s_ channel; tuser carries the request kind and tdata
// the element index and value and the x, y, z operands. Each change of the
// matrix sends all sixteen elements on the m_ channel, index order, tlast on
// index 15.
// Loading an operand element below 15 sends nothing.
// Operand element 15, translate and scale run 64 products through the single
// 32x32 multiplier, one per cycle, then wait for the pipeline to drain; each
// element is then emitted in a memory read step and an output load step.
// Load identity skips the products.
// s_tready is high only while the sequencer waits for a request; it rises
// again once the last element sits in the output register.
// A stalled receiver holds the output register and pauses the emit steps.
// Reset restores the identity matrix and clears the operand stage at once.
module matrix4_transform_accumulator_top
  import mta_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // elem_index, elem_value, x_value, y_value, z_value
  input  logic [1:0]   s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,  // out_index, out_value
  output logic         m_tlast
);

  in_item_t    item;
  ctrl_t       ctrl;
  status_t     status;
  logic [3:0]  out_index;
  logic [31:0] out_value;

  assign item.req_type   = s_tuser;
  assign item.elem_index = s_tdata[3:0];
  assign item.elem_value = s_tdata[35:4];
  assign item.x_value    = s_tdata[67:36];
  assign item.y_value    = s_tdata[99:68];
  assign item.z_value    = s_tdata[131:100];

  mta_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .req_type   (s_tuser),
    .elem_index (s_tdata[3:0]),
    .status     (status),
    .ctrl       (ctrl)
  );

  mta_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ctrl      (ctrl),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .out_index (out_index),
    .out_value (out_value),
    .last_flag (m_tlast)
  );

  assign s_tready = ctrl.in_ready;
  assign m_tdata  = {4'b0, out_value, out_index};

  a_flip_drained: assert property (@(posedge clk) disable iff (rst)
    ctrl.flip |-> status.pipe_empty && !ctrl.mac_issue)
    else $error("bank flip with products in flight");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_ld |-> !m_tvalid)
    else $error("output register overwritten");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> status.pipe_empty)
    else $error("request taken while products in flight");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tready |=> !m_tvalid)
    else $error("element sent right after last of matrix");

endmodule
